@@ hdl/tnis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnis_pkg
// Shared types and constants for the triangle normal and index split unit.
// ----------------------------------------------------------------------------
package tnis_pkg;

  localparam int COORD_WIDTH      = 32;
  localparam int INDEX_WIDTH      = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int VIDX_WIDTH       = 24;
  localparam int NORM_WIDTH       = 16;
  localparam int MAG_BITS         = 30;
  localparam int TRI_VERTS        = 3;

  localparam logic [1:0] PRIM_POINT = 2'd0;
  localparam logic [1:0] PRIM_LINE  = 2'd1;
  localparam logic [1:0] PRIM_TRI   = 2'd2;
  // Unused kind code; the unit handles it like a point.
  localparam logic [1:0] PRIM_RSVD  = 2'd3;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_TRI  = 1'b1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic [1:0]                    prim_type;
    logic                          end_of_model;
  } vtx_t;

  typedef struct packed {
    logic                         kind_out;
    logic [VIDX_WIDTH-1:0]        vertex_index;
    logic signed [NORM_WIDTH-1:0] normal_x;
    logic signed [NORM_WIDTH-1:0] normal_y;
    logic signed [NORM_WIDTH-1:0] normal_z;
    logic                         degenerate;
    logic                         last;
  } res_t;

endpackage

@@ hdl/tnis_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnis_mul
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tnis_mul #(
  parameter int W = 30
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] p
);

  localparam int CNTW = (W > 1) ? $clog2(W) : 1;

  logic [2*W-1:0] acc;
  logic [2*W-1:0] mc;
  logic [W-1:0]   mp;
  logic [CNTW-1:0] cnt;
  logic           run;

  assign p = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc <= '0;
        mc  <= (2*W)'(a);
        mp  <= b;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (mp[0]) begin
          acc <= acc + mc;
        end
        mc  <= mc << 1;
        mp  <= mp >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/tnis_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnis_sqrt
// Digit-by-digit integer square root, one root bit per cycle (floor).
// ----------------------------------------------------------------------------
module tnis_sqrt #(
  parameter int R = 31
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*R-1:0] s,
  output logic           done,
  output logic [R-1:0]   root
);

  localparam int CNTW = (R > 1) ? $clog2(R) : 1;

  logic [2*R-1:0]  sr;
  logic [R+2:0]    rem;
  logic [R+2:0]    rem2;
  logic [R+2:0]    trial;
  logic [CNTW-1:0] cnt;
  logic            run;

  assign rem2  = {rem[R:0], sr[2*R-1 -: 2]};
  assign trial = (R+3)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sr   <= s;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        if (rem2 >= trial) begin
          rem  <= rem2 - trial;
          root <= {root[R-2:0], 1'b1};
        end else begin
          rem  <= rem2;
          root <= {root[R-2:0], 1'b0};
        end
        sr  <= sr << 2;
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(R - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/tnis_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnis_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tnis_div #(
  parameter int NW = 45,
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW);

  logic [NW-1:0]   nr;
  logic [DW-1:0]   dr;
  logic [DW:0]     rem;
  logic [DW:0]     r2;
  logic [CNTW-1:0] cnt;
  logic            run;

  assign r2 = {rem[DW-1:0], nr[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nr  <= num;
        dr  <= den;
        rem <= '0;
        quo <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (r2 >= {1'b0, dr}) begin
          rem <= r2 - {1'b0, dr};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= r2;
          quo <= {quo[NW-2:0], 1'b0};
        end
        nr  <= nr << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/triangle_normal_and_index_split_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_normal_and_index_split_unit
// Splits model vertices into line and triangle index beats and computes
// a Q2.14 unit face normal for each complete triangle.
// ----------------------------------------------------------------------------
// Point and line vertices and the first two vertices of a triangle are taken
// one per cycle while the result register is free. The third vertex of a
// triangle starts the normal computation, which holds off new vertices until
// its three beats have been sent. The length of that computation is set by
// the shared bit-serial multiplier (six cross-product terms and three
// squares), the bit-serial square root and the bit-serial divider used once
// per component, with normalizing shifts before the products and before the
// squares. A degenerate triangle skips the squares, the root and the
// divisions. The three triangle beats then leave on consecutive cycles when
// the sink is ready.
module triangle_normal_and_index_split_unit #(
  parameter int INDEX_WIDTH      = tnis_pkg::INDEX_WIDTH,
  parameter int NORMAL_FRAC_BITS = tnis_pkg::NORMAL_FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           vtx_valid,
  output logic           vtx_ready,
  input  tnis_pkg::vtx_t vtx,
  output logic           res_valid,
  input  logic           res_ready,
  output tnis_pkg::res_t res
);

  import tnis_pkg::*;

  localparam int MB  = MAG_BITS;
  localparam int DMW = COORD_WIDTH + 1;
  localparam int CMW = 2 * MB + 1;
  localparam int SW  = 2 * MB + 2;
  localparam int LW  = MB + 1;
  localparam int NW  = MB + 1 + NORMAL_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DNORM, S_MUL, S_CNORM, S_SQ, S_SQRT, S_DIV, S_EMIT
  } state_t;

  state_t state;

  logic [1:0]                    phase;
  logic [INDEX_WIDTH-1:0]        vcount;
  logic [INDEX_WIDTH-1:0]        first_idx;
  logic signed [COORD_WIDTH-1:0] hold0 [3];
  logic signed [COORD_WIDTH-1:0] hold1 [3];

  logic [DMW-1:0]        dm [6];
  logic                  dn [6];
  logic [2:0]            mi;
  logic [1:0]            k;
  logic                  op_run;
  logic signed [SW-1:0]  acc;
  logic [CMW-1:0]        cm [3];
  logic                  cn [3];
  logic [SW-1:0]         ssum;
  logic [LW-1:0]         len;
  logic [NORM_WIDTH-1:0] nrm [3];
  logic                  degen;

  // Differences of the second held vertex and of the incoming vertex against the first held one.
  logic signed [DMW-1:0] dsub [6];
  logic signed [COORD_WIDTH-1:0] vin [3];

  logic          accept;
  logic          out_free;
  logic          mul_start;
  logic [MB-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic          pair_neg;
  logic          mul_done;
  logic [2*MB-1:0] mul_p;
  logic          sqrt_start;
  logic          sqrt_done;
  logic [LW-1:0] sqrt_root;
  logic          div_start;
  logic          div_done;
  logic [NW-1:0] div_num;
  logic [NW-1:0] div_quo;

  logic signed [SW-1:0]  sp;
  logic signed [SW-1:0]  cdiff;
  logic [CMW-1:0]        cmag;
  logic                  d_big;
  logic                  c_zero;
  logic                  c_big;
  logic                  c_small;
  logic [NORM_WIDTH-1:0] qv;

  assign out_free  = !res_valid || res_ready;
  assign vtx_ready = (state == S_IDLE) && out_free;
  assign accept    = vtx_valid && vtx_ready;

  assign vin[0] = vtx.pos_x;
  assign vin[1] = vtx.pos_y;
  assign vin[2] = vtx.pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsub[i]     = DMW'(hold1[i]) - DMW'(hold0[i]);
      dsub[i + 3] = DMW'(vin[i]) - DMW'(hold0[i]);
    end
  end

  always_comb begin
    d_big   = 1'b0;
    c_zero  = 1'b1;
    c_big   = 1'b0;
    c_small = 1'b1;
    for (int i = 0; i < 6; i++) begin
      d_big = d_big | ((dm[i] >> MB) != '0);
    end
    for (int i = 0; i < 3; i++) begin
      c_zero  = c_zero & (cm[i] == '0);
      c_big   = c_big | ((cm[i] >> MB) != '0);
      c_small = c_small & ((cm[i] >> (MB - 1)) == '0);
    end
  end

  // Cross product term pairs: c0 = d1*d5 - d2*d4, c1 = d2*d3 - d0*d5,
  // c2 = d0*d4 - d1*d3.
  always_comb begin
    mul_a    = MB'(cm[0]);
    mul_b    = MB'(cm[0]);
    pair_neg = 1'b0;
    if (state == S_MUL) begin
      case (mi)
        3'd0: begin mul_a = MB'(dm[1]); mul_b = MB'(dm[5]); pair_neg = dn[1] ^ dn[5]; end
        3'd1: begin mul_a = MB'(dm[2]); mul_b = MB'(dm[4]); pair_neg = dn[2] ^ dn[4]; end
        3'd2: begin mul_a = MB'(dm[2]); mul_b = MB'(dm[3]); pair_neg = dn[2] ^ dn[3]; end
        3'd3: begin mul_a = MB'(dm[0]); mul_b = MB'(dm[5]); pair_neg = dn[0] ^ dn[5]; end
        3'd4: begin mul_a = MB'(dm[0]); mul_b = MB'(dm[4]); pair_neg = dn[0] ^ dn[4]; end
        3'd5: begin mul_a = MB'(dm[1]); mul_b = MB'(dm[3]); pair_neg = dn[1] ^ dn[3]; end
        default: begin mul_a = '0; mul_b = '0; pair_neg = 1'b0; end
      endcase
    end
  end

  assign sp    = pair_neg ? -SW'(mul_p) : SW'(mul_p);
  assign cdiff = acc - sp;
  assign cmag  = cdiff[SW-1] ? CMW'(-cdiff) : CMW'(cdiff);

  assign mul_start  = ((state == S_MUL) || (state == S_SQ)) && !op_run;
  assign sqrt_start = (state == S_SQRT) && !op_run;
  assign div_start  = (state == S_DIV) && !op_run;
  assign div_num    = (NW'(cm[0][MB-1:0]) << NORMAL_FRAC_BITS) + NW'(len >> 1);
  assign qv         = NORM_WIDTH'(div_quo);

  tnis_mul #(.W(MB)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  tnis_sqrt #(.R(LW)) u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .s    (ssum),
    .done (sqrt_done),
    .root (sqrt_root)
  );

  tnis_div #(.NW(NW), .DW(LW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (len),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 2'd0;
      vcount    <= '0;
      first_idx <= '0;
      op_run    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (mul_start || sqrt_start || div_start) begin
        op_run <= 1'b1;
      end
      if (mul_done || sqrt_done || div_done) begin
        op_run <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            vcount <= vcount + 1'b1;
            if (vtx.prim_type == PRIM_LINE) begin
              res_valid        <= 1'b1;
              res.kind_out     <= KIND_LINE;
              res.vertex_index <= VIDX_WIDTH'(vcount);
              res.normal_x     <= '0;
              res.normal_y     <= '0;
              res.normal_z     <= '0;
              res.degenerate   <= 1'b0;
              res.last         <= 1'b1;
            end else if (vtx.prim_type == PRIM_TRI) begin
              if (phase == 2'd0) begin
                first_idx <= vcount;
                for (int i = 0; i < 3; i++) hold0[i] <= vin[i];
                phase <= 2'd1;
              end else if (phase == 2'd1) begin
                for (int i = 0; i < 3; i++) hold1[i] <= vin[i];
                phase <= 2'd2;
              end else begin
                for (int i = 0; i < 6; i++) begin
                  dn[i] <= dsub[i][DMW-1];
                  dm[i] <= dsub[i][DMW-1] ? DMW'(-dsub[i]) : DMW'(dsub[i]);
                end
                phase <= 2'd0;
                state <= S_DNORM;
              end
            end
            if (vtx.end_of_model) begin
              phase  <= 2'd0;
              vcount <= '0;
            end
          end
        end

        S_DNORM: begin
          if (d_big) begin
            for (int i = 0; i < 6; i++) dm[i] <= dm[i] >> 1;
          end else begin
            mi    <= 3'd0;
            state <= S_MUL;
          end
        end

        S_MUL: begin
          if (mul_done) begin
            mi <= mi + 1'b1;
            if (!mi[0]) begin
              acc <= sp;
            end else begin
              // Shift the finished component in; after three it sits in cm[0].
              cm[2] <= cmag;
              cn[2] <= cdiff[SW-1];
              cm[0] <= cm[1];
              cn[0] <= cn[1];
              cm[1] <= cm[2];
              cn[1] <= cn[2];
              if (mi == 3'd5) begin
                state <= S_CNORM;
              end
            end
          end
        end

        S_CNORM: begin
          if (c_zero) begin
            degen <= 1'b1;
            for (int i = 0; i < 3; i++) nrm[i] <= '0;
            k     <= 2'd0;
            state <= S_EMIT;
          end else if (c_big) begin
            for (int i = 0; i < 3; i++) cm[i] <= cm[i] >> 1;
          end else if (c_small) begin
            for (int i = 0; i < 3; i++) cm[i] <= cm[i] << 1;
          end else begin
            degen <= 1'b0;
            ssum  <= '0;
            k     <= 2'd0;
            state <= S_SQ;
          end
        end

        S_SQ: begin
          if (mul_done) begin
            ssum  <= ssum + SW'(mul_p);
            cm[0] <= cm[1];
            cm[1] <= cm[2];
            cm[2] <= cm[0];
            cn[0] <= cn[1];
            cn[1] <= cn[2];
            cn[2] <= cn[0];
            k     <= k + 1'b1;
            if (k == 2'd2) begin
              state <= S_SQRT;
            end
          end
        end

        S_SQRT: begin
          if (sqrt_done) begin
            len   <= sqrt_root;
            k     <= 2'd0;
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            nrm[2] <= cn[0] ? -qv : qv;
            nrm[0] <= nrm[1];
            nrm[1] <= nrm[2];
            cm[0]  <= cm[1];
            cm[1]  <= cm[2];
            cm[2]  <= cm[0];
            cn[0]  <= cn[1];
            cn[1]  <= cn[2];
            cn[2]  <= cn[0];
            k      <= k + 1'b1;
            if (k == 2'd2) begin
              k     <= 2'd0;
              state <= S_EMIT;
            end
          end
        end

        S_EMIT: begin
          if (out_free) begin
            res_valid        <= 1'b1;
            res.kind_out     <= KIND_TRI;
            res.vertex_index <= VIDX_WIDTH'(first_idx + INDEX_WIDTH'(k));
            res.normal_x     <= nrm[0];
            res.normal_y     <= nrm[1];
            res.normal_z     <= nrm[2];
            res.degenerate   <= degen;
            res.last         <= (k == 2'(TRI_VERTS - 1));
            k                <= k + 1'b1;
            if (k == 2'(TRI_VERTS - 1)) begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/tnis_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnis_checker
// Port-level checks for the triangle normal and index split unit.
// ----------------------------------------------------------------------------
module tnis_checker (
  input logic           clk,
  input logic           rst,
  input logic           vtx_valid,
  input logic           vtx_ready,
  input tnis_pkg::vtx_t vtx,
  input logic           res_valid,
  input logic           res_ready,
  input tnis_pkg::res_t res
);

  import tnis_pkg::*;

  // A stalled result beat holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // Line beats are single and carry no normal.
  a_line_beat: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind_out == KIND_LINE) |->
      res.last && !res.degenerate && (res.normal_x == '0) &&
      (res.normal_y == '0) && (res.normal_z == '0))
    else $error("malformed line beat");

  // A degenerate triangle reports a zero normal.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.degenerate |->
      (res.normal_x == '0) && (res.normal_y == '0) && (res.normal_z == '0))
    else $error("degenerate triangle with nonzero normal");

  // No vertex is taken while a triangle still has beats to send.
  a_no_take_mid_tri: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> !vtx_ready)
    else $error("vertex taken during triangle beats");

  // Once a non-final triangle beat is taken, the next one follows at once.
  a_tri_follow: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res.last |=>
      res_valid && (res.kind_out == KIND_TRI))
    else $error("triangle beats not back to back");

endmodule

bind triangle_normal_and_index_split_unit tnis_checker u_tnis_checker (.*);
